// ----- rtl/core/fmbq_pkg.sv -----
// fmbq_pkg: constants, operation codes and the cell control type for the
// front/middle/back queue. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fmbq_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [2:0] KIND_INS_FRONT = 3'd0;
	localparam logic [2:0] KIND_INS_MID   = 3'd1;
	localparam logic [2:0] KIND_INS_BACK  = 3'd2;
	localparam logic [2:0] KIND_REM_FRONT = 3'd3;
	localparam logic [2:0] KIND_REM_MID   = 3'd4;
	localparam logic [2:0] KIND_REM_BACK  = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [IDX_W-1:0]  pos;
		logic [DATA_W-1:0] value;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/front_middle_back_queue.sv -----
// front_middle_back_queue: top level, operation decode, entry count, cell
// chain and result register. Depends on fmbq_pkg and fmbq_cell.
//
//   beat      direction  handshake           payload
//   in        receive    in_valid/in_stall   kind, value
//   out       send       out_valid/out_stall popped_value, status, occupancy
//
// One beat in, one beat out; each accepted operation updates the cell chain.
// The result is registered and appears the cycle after the input beat.
// Input is stalled only while a result is held and the output is stalled.
// Reset clears the count and result valid; entry contents need no reset.
`timescale 1ns / 1ps
`default_nettype none

module front_middle_back_queue
	import fmbq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        kind,
	input  wire logic [DATA_W-1:0] value,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [DATA_W-1:0]      popped_value,
	output logic [1:0]             status,
	output logic [CNT_W-1:0]       occupancy
);

	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] popped_q;
	logic [1:0]        status_q;
	logic [CNT_W-1:0]  occ_q;

	logic              fire;
	logic              is_push;
	logic              is_pop;
	logic              full;
	logic              empty;
	logic [CNT_W-1:0]  count_m1;
	logic [IDX_W-1:0]  pos;
	cell_ctl_t         ctl;
	logic [DATA_W-1:0] popped;
	logic [1:0]        st;
	logic [CNT_W-1:0]  count_nxt;

	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [DATA_W-1:0] cell_tap  [CAPACITY];

	assign in_stall = out_valid_q && out_stall;
	assign fire     = in_valid && !in_stall;

	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);
	assign count_m1 = count_q - CNT_W'(1);

	always_comb begin
		is_push = 1'b0;
		is_pop  = 1'b0;
		pos     = '0;
		case (kind)
			KIND_INS_FRONT: begin
				is_push = 1'b1;
			end
			KIND_INS_MID: begin
				is_push = 1'b1;
				pos     = IDX_W'(count_q >> 1);
			end
			KIND_INS_BACK: begin
				is_push = 1'b1;
				pos     = IDX_W'(count_q);
			end
			KIND_REM_FRONT: begin
				is_pop = 1'b1;
			end
			KIND_REM_MID: begin
				is_pop = 1'b1;
				pos    = IDX_W'(count_m1 >> 1);
			end
			KIND_REM_BACK: begin
				is_pop = 1'b1;
				pos    = IDX_W'(count_m1);
			end
			default: begin
				is_push = 1'b0;
			end
		endcase
	end

	assign ctl.ins   = fire && is_push && !full;
	assign ctl.rem   = fire && is_pop && !empty;
	assign ctl.pos   = pos;
	assign ctl.value = value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_d;
		logic [DATA_W-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		fmbq_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(i)),
			.ctl        (ctl),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.tap        (cell_tap[i])
		);
	end

	always_comb begin
		popped = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			popped = popped | cell_tap[i];
		end
	end

	always_comb begin
		st = ST_OK;
		if (is_push && full) begin
			st = ST_FULL;
		end else if (is_pop && empty) begin
			st = ST_EMPTY;
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (ctl.ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctl.rem) begin
			count_nxt = count_m1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			popped_q <= popped;
			status_q <= st;
			occ_q    <= count_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_value = popped_q;
	assign status       = status_q;
	assign occupancy    = occ_q;

endmodule

`default_nettype wire

// ----- rtl/core/fmbq_cell.sv -----
// fmbq_cell: one storage position of the queue chain. Holds, loads, takes
// its left neighbor or its right neighbor each cycle. Depends on fmbq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmbq_cell
	import fmbq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic [IDX_W-1:0]  idx,
	input  wire cell_ctl_t         ctl,
	input  wire logic [DATA_W-1:0] left_data,
	input  wire logic [DATA_W-1:0] right_data,
	output logic [DATA_W-1:0]      data,
	output logic [DATA_W-1:0]      tap
);

	logic [DATA_W-1:0] data_q;
	logic              at_pos;
	logic              above_pos;

	assign at_pos    = (idx == ctl.pos);
	assign above_pos = (idx > ctl.pos);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (at_pos) begin
				data_q <= ctl.value;
			end else if (above_pos) begin
				data_q <= left_data;
			end
		end else if (ctl.rem) begin
			if (at_pos || above_pos) begin
				data_q <= right_data;
			end
		end
	end

	assign data = data_q;
	assign tap  = (ctl.rem && at_pos) ? data_q : '0;

endmodule

`default_nettype wire

// ----- rtl/core/fmbq_checker.sv -----
// fmbq_checker: port-level checks for front_middle_back_queue, bound to the
// top level. Depends on fmbq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmbq_checker
	import fmbq_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [DATA_W-1:0] popped_value,
	input wire logic [1:0]        status,
	input wire logic [CNT_W-1:0]  occupancy
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(popped_value)
			&& $stable(status) && $stable(occupancy))
		else $error("result changed while stalled");

	a_beat_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted beat gave no result");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> occupancy == CNT_W'(CAPACITY)
			&& popped_value == '0)
		else $error("full status with queue not full");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> occupancy == '0 && popped_value == '0)
		else $error("empty status with queue not empty");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occupancy <= CNT_W'(CAPACITY))
		else $error("occupancy beyond capacity");

endmodule

bind front_middle_back_queue fmbq_checker u_fmbq_checker (.*);

`default_nettype wire
